FILE: hdl/ssl_pkg.sv
package ssl_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } ssl_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } ssl_rsp_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic capture;
        logic ins;
        logic del;
    } ssl_cmd_t;

endpackage

FILE: hdl/ssl_stream_if.sv
interface ssl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ssl_cell.sv
module ssl_cell import ssl_pkg::*; (
    input  logic                      clk,
    input  ssl_cmd_t                  cmd,
    input  logic                      occupied,
    input  logic signed [VALUE_W-1:0] probe,
    input  logic signed [VALUE_W-1:0] key,
    input  logic signed [VALUE_W-1:0] left_entry,
    input  logic                      left_lt,
    input  logic signed [VALUE_W-1:0] right_entry,
    output logic signed [VALUE_W-1:0] entry,
    output logic                      lt,
    output logic                      eq
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      lt_reg;
    logic                      eq_reg;

    // An entry at or above the key moves: right on insert, left on delete.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && !lt_reg)
        begin
            entry_next = left_lt ? key : left_entry;
        end
        else if (cmd.del && !lt_reg)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (cmd.capture)
        begin
            lt_reg <= occupied && (entry_reg < probe);
            eq_reg <= occupied && (entry_reg == probe);
        end
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

FILE: hdl/sorted_set_table.sv
// sorted_set_table keeps up to CAPACITY distinct signed 32-bit values in
// ascending order in a row of compare-and-shift cells, one value per cell.
// Each input item carries an operation (insert, delete or find) and a value,
// and yields exactly one result item with a status code and the entry count
// after the operation. In the cycle an item is accepted every cell compares
// its value against the incoming key and registers the outcome; then, once
// the output register is free, the hit is gathered across the row, the
// cells shift by one place toward or away from the key position, and the
// result is loaded into the output register. The input is ready again once
// that update is done, so a new item is not taken while one is at work;
// a result that waits at the output holds the update, and with it the input,
// until it is taken. No clearing pass is needed after reset: cells at or
// above the count are never compared as occupied.
module sorted_set_table import ssl_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    ssl_stream_if.sink   in_ch,
    ssl_stream_if.source out_ch
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                      busy_reg;
    logic                      busy_next;
    logic [KIND_W-1:0]         kind_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    ssl_rsp_t                  out_data_reg;

    logic                      accept;
    logic                      fire;
    logic                      hit;
    logic                      full;
    logic                      do_ins;
    logic                      do_del;
    logic [STATUS_W-1:0]       status;
    ssl_cmd_t                  cmd;

    logic signed [VALUE_W-1:0] entry [CAPACITY];
    logic [CAPACITY-1:0]       lt;
    logic [CAPACITY-1:0]       eq;
    logic [CAPACITY-1:0]       occupied;

    assign in_ch.ready = !busy_reg;
    assign accept      = in_ch.valid && in_ch.ready;

    // The update may only proceed once the output register is free.
    assign fire = busy_reg && (!out_valid_reg || out_ch.ready);

    assign hit    = |eq;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign do_ins = fire && (kind_reg == KIND_INSERT) && !hit && !full;
    assign do_del = fire && (kind_reg == KIND_DELETE) && hit;

    assign cmd.capture = accept;
    assign cmd.ins     = do_ins;
    assign cmd.del     = do_del;

    always_comb
    begin
        case (kind_reg)
            KIND_INSERT: status = hit ? ST_PRESENT : (full ? ST_FULL : ST_INSERTED);
            KIND_DELETE: status = hit ? ST_DELETED : ST_NOT_FOUND;
            KIND_FIND:   status = hit ? ST_FOUND : ST_NOT_FOUND;
            default:     status = ST_NOT_FOUND;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (fire)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= in_ch.data.kind;
            key_reg  <= in_ch.data.value;
        end
        if (fire)
        begin
            out_data_reg.status <= status;
            out_data_reg.count  <= COUNT_W'(count_next);
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // The row of cells. The first cell sees the key as its left neighbor,
    // and the last cell, with no right neighbor, takes the key instead.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_entry;
        logic                      left_lt;
        logic signed [VALUE_W-1:0] right_entry;

        assign occupied[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_entry = key_reg;
            assign left_lt    = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_entry = entry[i-1];
            assign left_lt    = lt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = key_reg;
        end
        else
        begin : g_inner_right
            assign right_entry = entry[i+1];
        end

        ssl_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (occupied[i]),
            .probe       (in_ch.data.value),
            .key         (key_reg),
            .left_entry  (left_entry),
            .left_lt     (left_lt),
            .right_entry (right_entry),
            .entry       (entry[i]),
            .lt          (lt[i]),
            .eq          (eq[i])
        );
    end

endmodule

FILE: hdl/ssl_checker.sv
module ssl_checker import ssl_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] out_status,
    input logic [COUNT_W-1:0]  out_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_status) && $stable(out_count))
        else $error("stalled result item changed");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while one is at work");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_count) <= CAPACITY) || (CAPACITY > 31))
        else $error("count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == ST_FULL) |-> out_count == COUNT_W'(CAPACITY))
        else $error("full reported below capacity");

endmodule

bind sorted_set_table ssl_checker #(.CAPACITY(CAPACITY)) u_ssl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.data.status),
    .out_count  (out_ch.data.count)
);

FILE: test/tb_sorted_set_table.sv
`timescale 1ns / 1ps

module tb_sorted_set_table;
    import ssl_pkg::*;

    // The table is built at its default depth, so the full-table case is
    // reached after sixteen distinct inserts.
    localparam int TABLE_DEPTH   = CAPACITY_DEFAULT;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 600000;

    // Kind 3 is not an operation. The block must answer it as not found and
    // must leave the set alone.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    logic clk;
    logic rst_n;

    ssl_stream_if #(.payload_t(ssl_req_t)) in_if ();
    ssl_stream_if #(.payload_t(ssl_rsp_t)) out_if ();

    sorted_set_table #(
        .CAPACITY(TABLE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_if),
        .out_ch(out_if)
    );

    // Our own copy of the set, kept in ascending signed order. Its size is
    // the entry count.
    logic signed [VALUE_W-1:0] held_keys[$];

    // Results owed by the block, oldest first.
    ssl_rsp_t expected_rsp_q[$];

    int unsigned mismatch_count = 0;

    // Knobs that the stimulus turns for the result side. A stall percentage
    // of zero keeps ready high throughout, which gives stretches with no
    // idling at all.
    int unsigned rx_stall_pct = 0;
    bit          long_hold_req = 1'b0;
    bit          tx_gapless = 1'b0;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Applies one operation to the set and returns the status and count
    // that the block must report for it. The search stops at the first held
    // key that is not below the incoming one, which is also where a new key
    // goes in.
    function automatic ssl_rsp_t predict_table_op(input ssl_req_t req);
        logic signed [VALUE_W-1:0] key;
        int                        pos;
        bit                        hit;
        ssl_rsp_t                  rsp;
        key = $signed(req.value);
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < key)
        begin
            pos++;
        end
        hit = (pos < held_keys.size()) && (held_keys[pos] == key);
        rsp.status = ST_NOT_FOUND;
        case (req.kind)
            KIND_INSERT:
            begin
                if (hit)
                begin
                    rsp.status = ST_PRESENT;
                end
                else if (held_keys.size() >= TABLE_DEPTH)
                begin
                    rsp.status = ST_FULL;
                end
                else
                begin
                    held_keys.insert(pos, key);
                    rsp.status = ST_INSERTED;
                end
            end
            KIND_DELETE:
            begin
                if (hit)
                begin
                    held_keys.delete(pos);
                    rsp.status = ST_DELETED;
                end
            end
            KIND_FIND:
            begin
                if (hit)
                begin
                    rsp.status = ST_FOUND;
                end
            end
            default:
            begin
                rsp.status = ST_NOT_FOUND;
            end
        endcase
        rsp.count = COUNT_W'(held_keys.size());
        return rsp;
    endfunction

    // Growing phases lean on inserts so the table fills up; shrinking phases
    // lean on deletes so it drains back to empty. Finds and the unused kind
    // are mixed into both.
    function automatic logic [KIND_W-1:0] pick_kind(input bit grow);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < (grow ? 55 : 15))
        begin
            return KIND_INSERT;
        end
        if (r < 70)
        begin
            return KIND_DELETE;
        end
        if (r < 95)
        begin
            return KIND_FIND;
        end
        return KIND_UNUSED;
    endfunction

    // Deletes and finds mostly aim at keys that are held, so they hit.
    // Inserts mostly bring new keys. The rest comes from a narrow band
    // around zero, which collides often, from the ends of the signed range,
    // and from the full 32-bit space.
    function automatic logic signed [VALUE_W-1:0] pick_value(input logic [KIND_W-1:0] kind);
        int unsigned r;
        int unsigned held_pct;
        held_pct = (kind == KIND_INSERT) ? 25 : 75;
        r = $urandom_range(0, 99);
        if (r < held_pct && held_keys.size() != 0)
        begin
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        end
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            return $signed($urandom_range(0, 40)) - 20;
        end
        if (r < 6)
        begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MIN + 1;
                2: return VAL_MAX - 1;
                default: return VAL_MAX;
            endcase
        end
        return $urandom;
    endfunction

    // Sender gap before the next item: mostly none or a few cycles, now and
    // then a long one.
    function automatic int unsigned tx_gap();
        int unsigned r;
        if (tx_gapless)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // Drops valid for the gap. With no gap, valid stays high into the next
    // item so that it is not lowered and raised in one time step.
    task automatic idle_sender(input int unsigned cycles);
        if (cycles > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Offers one item and holds it until the block takes it. The set is
    // updated at the edge where the item is accepted. A row with a typed
    // result queues that result, while the set is still updated so that
    // later rows are predicted from the right contents.
    task automatic send_item(input ssl_req_t req, input bit typed, input ssl_rsp_t typed_rsp);
        ssl_rsp_t predicted;
        in_if.valid <= 1'b1;
        in_if.data  <= req;
        do
        begin
            @(posedge clk);
        end
        while (!in_if.ready);
        predicted = predict_table_op(req);
        expected_rsp_q.push_back(typed ? typed_rsp : predicted);
    endtask

    // Holds off the input until every owed result has come back. At least
    // one edge passes, so valid is never dropped and raised in one step.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_rsp_q.size() != 0);
    endtask

    // Directed opening. The empty set, the unused kind and the removal of the
    // last entry come first. Then both ends of the signed range go in, the
    // table is filled to the top with keys that all land between those two
    // ends, and a new key is refused as full, while a key that is held still
    // reads as present. The fill rows carry no typed result and are checked
    // against the running set.
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
    } script_row_t;

    localparam int N_ROWS = 27;

    script_row_t directed_rows [N_ROWS] = '{
        '{KIND_FIND,   32'sd0,          1'b1, ST_NOT_FOUND, 5'd0},
        '{KIND_DELETE, -32'sd5,         1'b1, ST_NOT_FOUND, 5'd0},
        '{KIND_UNUSED, -32'sd1,         1'b1, ST_NOT_FOUND, 5'd0},
        '{KIND_INSERT, VAL_MAX,         1'b1, ST_INSERTED,  5'd1},
        '{KIND_DELETE, VAL_MAX,         1'b1, ST_DELETED,   5'd0},
        '{KIND_INSERT, VAL_MIN,         1'b1, ST_INSERTED,  5'd1},
        '{KIND_INSERT, VAL_MAX,         1'b1, ST_INSERTED,  5'd2},
        '{KIND_INSERT, VAL_MIN,         1'b1, ST_PRESENT,   5'd2},
        '{KIND_FIND,   VAL_MAX,         1'b1, ST_FOUND,     5'd2},
        '{KIND_DELETE, 32'sd0,          1'b1, ST_NOT_FOUND, 5'd2},
        '{KIND_INSERT, 32'sd0,          1'b0, '0,           '0},
        '{KIND_INSERT, -32'sd1,         1'b0, '0,           '0},
        '{KIND_INSERT, 32'sd1,          1'b0, '0,           '0},
        '{KIND_INSERT, 32'sd2,          1'b0, '0,           '0},
        '{KIND_INSERT, -32'sd2,         1'b0, '0,           '0},
        '{KIND_INSERT, 32'sd100,        1'b0, '0,           '0},
        '{KIND_INSERT, -32'sd100,       1'b0, '0,           '0},
        '{KIND_INSERT, 32'sh4000_0000,  1'b0, '0,           '0},
        '{KIND_INSERT, -32'sh4000_0000, 1'b0, '0,           '0},
        '{KIND_INSERT, 32'sd1000,       1'b0, '0,           '0},
        '{KIND_INSERT, -32'sd1000,      1'b0, '0,           '0},
        '{KIND_INSERT, 32'sd50,         1'b0, '0,           '0},
        '{KIND_INSERT, -32'sd50,        1'b0, '0,           '0},
        '{KIND_INSERT, 32'sd3,          1'b0, '0,           '0},
        '{KIND_INSERT, 32'sd7,          1'b1, ST_FULL,      5'd16},
        '{KIND_INSERT, VAL_MAX,         1'b1, ST_PRESENT,   5'd16},
        '{KIND_DELETE, VAL_MIN,         1'b1, ST_DELETED,   5'd15}
    };

    // Result side. Ready is driven from time zero. A long hold asked for by
    // the stimulus is counted out here, while the sender keeps offering,
    // so the block backs up and stops taking input. Otherwise ready drops
    // for short stalls, and now and then for a longer one, at the rate set
    // for the current phase.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (!rst_n)
            begin
                out_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < rx_stall_pct)
                begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                             : $urandom_range(1, 3);
                end
            end
        end
    end

    // Every result that leaves the block is matched against the oldest owed
    // one, field by field.
    always @(posedge clk)
    begin
        ssl_rsp_t owed;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $error("result item with none owed: status %0d, count %0d",
                       out_if.data.status, out_if.data.count);
                mismatch_count++;
            end
            else
            begin
                owed = expected_rsp_q.pop_front();
                if (out_if.data.status !== owed.status)
                begin
                    $error("status: expected %0d, actual %0d", owed.status, out_if.data.status);
                    mismatch_count++;
                end
                if (out_if.data.count !== owed.count)
                begin
                    $error("count: expected %0d, actual %0d", owed.count, out_if.data.count);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog. The slowest correct run stays far below this limit.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        ssl_req_t    req;
        ssl_rsp_t    typed_rsp;
        int unsigned sent;
        int unsigned block_idx;
        int unsigned block_len;
        bit          grow;

        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            idle_sender(tx_gap());
            req.kind = directed_rows[i].kind;
            req.value = directed_rows[i].value;
            typed_rsp.status = directed_rows[i].status;
            typed_rsp.count = directed_rows[i].count;
            send_item(req, directed_rows[i].typed, typed_rsp);
        end
        drain_results();

        // Random part, in phases that alternately fill and drain the table.
        // One early phase runs the sender flat out against a long hold on
        // the result side. Some phases end with the sender waiting for every
        // owed result, and one of them always does.
        sent = 0;
        block_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            block_len = $urandom_range(20, 80);
            grow = (block_idx % 2 == 0);
            tx_gapless = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: rx_stall_pct = 0;
                1: rx_stall_pct = 20;
                default: rx_stall_pct = 50;
            endcase
            if (block_idx == 3)
            begin
                tx_gapless = 1'b1;
                long_hold_req = 1'b1;
            end
            repeat (block_len)
            begin
                idle_sender(tx_gap());
                req.kind = pick_kind(grow);
                req.value = pick_value(req.kind);
                send_item(req, 1'b0, '0);
                sent++;
            end
            if (block_idx == 6 || $urandom_range(0, 4) == 0)
            begin
                drain_results();
            end
            block_idx++;
        end

        in_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
        // A few more cycles so that a stray extra result would be caught.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/ssl_pkg.sv
hdl/ssl_stream_if.sv
hdl/ssl_cell.sv
hdl/sorted_set_table.sv
hdl/ssl_checker.sv
test/tb_sorted_set_table.sv
